[rtl/core/sups_pkg.sv]
// Package with the shared constants and types of the sorted unique pair set.
`default_nettype none
package sups_pkg;
  localparam int CAPACITY = 64;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_POP    = 2'd1;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_POPPED    = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;
  localparam logic [2:0] ST_CLEARED   = 3'd5;

  localparam logic [31:0] SIGN_FLIP = 32'h8000_0000;

  typedef struct packed {
    logic load;
    logic compare;
    logic apply;
  } sups_cmd_t;
endpackage
`default_nettype wire

[rtl/core/sups_if.sv]
// Request and response channel interfaces of the sorted unique pair set.
`default_nettype none
interface sups_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [31:0] first_value;
  logic signed [31:0] second_value;
  modport source (output valid, req_type, first_value, second_value, input ready);
  modport sink (input valid, req_type, first_value, second_value, output ready);
endinterface

interface sups_rsp_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [31:0] popped_first;
  logic signed [31:0] popped_second;
  logic [6:0]         held_count;
  modport source (output valid, status, popped_first, popped_second, held_count,
                  input ready);
  modport sink (input valid, status, popped_first, popped_second, held_count,
                output ready);
endinterface
`default_nettype wire

[rtl/core/sorted_unique_pair_set_top.sv]
// Top level of the sorted unique pair set: controller plus cell-row datapath.
// A request beat accepted in idle is stepped through a compare state and an apply
// state, and its response beat is then held valid in the response state.
// The response register holds until taken and no new request enters meanwhile.
// Reset (synchronous, rst high) empties the set and returns the controller to
// idle; the stored keys are left as they are and never read until rewritten.
`default_nettype none
module sorted_unique_pair_set_top
  import sups_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  sups_req_if.sink  req,
  sups_rsp_if.source rsp
);
  sups_cmd_t cmd;

  // The controller steps each request through compare and apply phases.
  sups_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  // The datapath holds the sorted row and forms the response beat.
  sups_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .req_type      (req.req_type),
    .first_value   (req.first_value),
    .second_value  (req.second_value),
    .status        (rsp.status),
    .popped_first  (rsp.popped_first),
    .popped_second (rsp.popped_second),
    .held_count    (rsp.held_count)
  );
endmodule
`default_nettype wire

[rtl/core/sups_ctrl.sv]
// Controller state machine sequencing load, compare, apply and response.
`default_nettype none
module sups_ctrl
  import sups_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output sups_cmd_t cmd
);
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CMP   = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;
  localparam logic [1:0] S_RESP  = 2'd3;

  logic [1:0] state, state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_CMP;
      S_CMP:   state_next = S_APPLY;
      S_APPLY: state_next = S_RESP;
      S_RESP:  if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign in_ready    = (state == S_IDLE);
  assign out_valid   = (state == S_RESP);
  assign cmd.load    = (state == S_IDLE) && in_valid;
  assign cmd.compare = (state == S_CMP);
  assign cmd.apply   = (state == S_APPLY);
endmodule
`default_nettype wire

[rtl/core/sups_datapath.sv]
// Sorted row of key cells with per-cell compare flags and the result register.
`default_nettype none
module sups_datapath
  import sups_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire sups_cmd_t          cmd,
  input  wire logic [1:0]         req_type,
  input  wire logic signed [31:0] first_value,
  input  wire logic signed [31:0] second_value,
  output logic [2:0]              status,
  output logic signed [31:0]      popped_first,
  output logic signed [31:0]      popped_second,
  output logic [6:0]              held_count
);
  logic [63:0]         cells [CAPACITY];
  logic [63:0]         key;
  logic [1:0]          op;
  logic [CNT_W-1:0]    count;
  logic [CAPACITY-1:0] lt_q, eq_q;
  logic                full, empty, dup;

  assign full  = (count == CNT_W'(CAPACITY));
  assign empty = (count == '0);
  assign dup   = |eq_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= req_type;
      key <= {32'(first_value) ^ SIGN_FLIP, 32'(second_value) ^ SIGN_FLIP};
    end
  end

  // Each cell compares its own key; entries at or above the count are masked.
  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      for (int i = 0; i < CAPACITY; i++) begin
        lt_q[i] <= (CNT_W'(i) < count) && (cells[i] < key);
        eq_q[i] <= (CNT_W'(i) < count) && (cells[i] == key);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      if (op == REQ_INSERT) begin
        if (!dup && !full) begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (!lt_q[i]) begin
              if (i == 0) cells[i] <= key;
              else if (lt_q[(i == 0) ? 0 : i - 1]) cells[i] <= key;
              else cells[i] <= cells[(i == 0) ? 0 : i - 1];
            end
          end
        end
      end else if (op == REQ_POP) begin
        if (!empty) begin
          for (int i = 0; i < CAPACITY - 1; i++) cells[i] <= cells[i + 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.apply) begin
      if (op == REQ_INSERT) begin
        if (!dup && !full) count <= count + 1'b1;
      end else if (op == REQ_POP) begin
        if (!empty) count <= count - 1'b1;
      end else begin
        count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      if (op == REQ_INSERT) begin
        popped_first  <= '0;
        popped_second <= '0;
        if (dup) begin
          status     <= ST_DUPLICATE;
          held_count <= 7'(count);
        end else if (full) begin
          status     <= ST_FULL;
          held_count <= 7'(count);
        end else begin
          status     <= ST_INSERTED;
          held_count <= 7'(count + 1'b1);
        end
      end else if (op == REQ_POP) begin
        if (empty) begin
          status        <= ST_EMPTY;
          popped_first  <= '0;
          popped_second <= '0;
          held_count    <= 7'(count);
        end else begin
          status        <= ST_POPPED;
          popped_first  <= signed'(cells[0][63:32] ^ SIGN_FLIP);
          popped_second <= signed'(cells[0][31:0] ^ SIGN_FLIP);
          held_count    <= 7'(count - 1'b1);
        end
      end else begin
        status        <= ST_CLEARED;
        popped_first  <= '0;
        popped_second <= '0;
        held_count    <= '0;
      end
    end
  end
endmodule
`default_nettype wire

[verif/sorted_unique_pair_set_top_test.sv]
// Testbench for the sorted unique pair set: directed and random insert, pop and clear beats checked against a model.
`timescale 1ns / 100ps
`default_nettype none
module sorted_unique_pair_set_top_test;
  import sups_pkg::*;

  // Request codes beyond the two that the package names.
  localparam logic [1:0] REQ_CLEAR = 2'd2;
  localparam logic [1:0] REQ_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] first_value;
    logic signed [31:0] second_value;
  } request_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] popped_first;
    logic signed [31:0] popped_second;
    logic [6:0]         held_count;
  } response_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  sups_req_if req ();
  sups_rsp_if rsp ();

  sorted_unique_pair_set_top DUT (.clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source));

  request_t  pending_requests[$];
  response_t expected_responses[$];
  int        send_idle_pct = 0;
  int        take_idle_pct = 0;
  bit        hold_requests = 1'b0;
  bit        failed = 1'b0;

  // Shadow copy of the set. Keys are the pair with both sign bits inverted, so an
  // unsigned compare of the 64-bit key orders pairs the way the block must.
  logic [63:0] shadow_keys[CAPACITY];
  int          shadow_count = 0;

  function automatic response_t predict_response(request_t r);
    response_t   res;
    logic [63:0] key;
    int          pos;
    res = '0;
    if (r.req_type == REQ_INSERT) begin
      key = {r.first_value ^ SIGN_FLIP, r.second_value ^ SIGN_FLIP};
      pos = 0;
      while (pos < shadow_count && shadow_keys[pos] < key) pos++;
      if (pos < shadow_count && shadow_keys[pos] == key) begin
        res.status = ST_DUPLICATE;
      end else if (shadow_count >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        for (int i = shadow_count; i > pos; i--) shadow_keys[i] = shadow_keys[i-1];
        shadow_keys[pos] = key;
        shadow_count++;
        res.status = ST_INSERTED;
      end
    end else if (r.req_type == REQ_POP) begin
      if (shadow_count == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.status = ST_POPPED;
        res.popped_first = shadow_keys[0][63:32] ^ SIGN_FLIP;
        res.popped_second = shadow_keys[0][31:0] ^ SIGN_FLIP;
        for (int i = 1; i < shadow_count; i++) shadow_keys[i-1] = shadow_keys[i];
        shadow_count--;
      end
    end else begin
      // Both the clear code and the spare code empty the set.
      shadow_count = 0;
      res.status = ST_CLEARED;
    end
    res.held_count = 7'(shadow_count);
    return res;
  endfunction

  // Driver: holds a beat until accepted, then either moves to the next or idles.
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (!req.valid || req.ready) begin
      if (req.valid) expected_responses.push_back(predict_response(
          {req.req_type, req.first_value, req.second_value}));
      if (pending_requests.size() > 0 && !hold_requests &&
          $urandom_range(99) >= send_idle_pct) begin
        request_t r;
        r = pending_requests.pop_front();
        req.valid <= 1'b1;
        req.req_type <= r.req_type;
        req.first_value <= r.first_value;
        req.second_value <= r.second_value;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each response beat against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_responses.size() == 0) begin
          $error("response beat with nothing expected: status %0d", rsp.status);
          failed = 1'b1;
        end else begin
          response_t e;
          e = expected_responses.pop_front();
          if (rsp.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, rsp.status);
            failed = 1'b1;
          end
          if (rsp.popped_first !== e.popped_first) begin
            $error("popped_first: expected %0d, got %0d", e.popped_first, rsp.popped_first);
            failed = 1'b1;
          end
          if (rsp.popped_second !== e.popped_second) begin
            $error("popped_second: expected %0d, got %0d", e.popped_second,
                   rsp.popped_second);
            failed = 1'b1;
          end
          if (rsp.held_count !== e.held_count) begin
            $error("held_count: expected %0d, got %0d", e.held_count, rsp.held_count);
            failed = 1'b1;
          end
        end
      end
      rsp.ready <= ($urandom_range(99) >= take_idle_pct);
    end
  end

  function automatic logic [31:0] pick_value(int span);
    // Mostly small ranges so duplicates and equal first values are common;
    // sometimes full-width values to exercise every bit and the sign.
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'h8000_0000 + $urandom_range(span);
      2: return 32'h7fff_ffff - $urandom_range(span);
      default: return $signed($urandom_range(2 * span)) - span;
    endcase
  endfunction

  task automatic queue_request(logic [1:0] op, logic [31:0] a, logic [31:0] b);
    pending_requests.push_back({op, a, b});
  endtask

  task automatic wait_drained();
    while (pending_requests.size() > 0 || req.valid || expected_responses.size() > 0)
      @(posedge clk);
  endtask

  // Random phase: fill runs push the set to full, drain runs pop it empty.
  task automatic queue_random(int count);
    int mode;
    for (int n = 0; n < count; n++) begin
      if (n % 150 == 0) mode = $urandom_range(2);
      case ($urandom_range(19))
        0: queue_request($urandom_range(1) ? REQ_CLEAR : REQ_SPARE, $urandom, $urandom);
        1, 2, 3, 4, 5: queue_request(REQ_POP, $urandom, $urandom);
        default: begin
          if (mode == 1 && $urandom_range(1)) queue_request(REQ_POP, $urandom, $urandom);
          else queue_request(REQ_INSERT, pick_value(mode == 0 ? 6 : 200),
                             pick_value(mode == 0 ? 6 : 200));
        end
      endcase
    end
  endtask

  initial begin
    req.valid = 1'b0;
    req.req_type = REQ_INSERT;
    req.first_value = '0;
    req.second_value = '0;
    rsp.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty pop, field extremes, ordering on the second value,
    // duplicates, spare code, then a full set with duplicate and reject.
    queue_request(REQ_POP, 32'h0, 32'h0);
    queue_request(REQ_INSERT, 32'h7fff_ffff, 32'h7fff_ffff);
    queue_request(REQ_INSERT, 32'h8000_0000, 32'h8000_0000);
    queue_request(REQ_INSERT, 32'h0, 32'hffff_ffff);
    queue_request(REQ_INSERT, 32'h0, 32'h1);
    queue_request(REQ_INSERT, 32'h0, 32'h1);
    queue_request(REQ_INSERT, 32'hffff_ffff, 32'h0);
    queue_request(REQ_POP, 32'hffff_ffff, 32'hffff_ffff);
    queue_request(REQ_POP, 32'h0, 32'h0);
    queue_request(REQ_SPARE, 32'h0, 32'h0);
    queue_request(REQ_POP, 32'h0, 32'h0);
    queue_request(REQ_INSERT, 32'h5555_5555, 32'haaaa_aaaa);
    queue_request(REQ_CLEAR, 32'hffff_ffff, 32'hffff_ffff);
    for (int i = 0; i < CAPACITY; i++) queue_request(REQ_INSERT, 32'(i / 3), 32'(-i));
    queue_request(REQ_INSERT, 32'h0, 32'h0);
    queue_request(REQ_INSERT, 32'h7fff_ffff, 32'h0);
    queue_request(REQ_POP, 32'h0, 32'h0);
    queue_request(REQ_INSERT, 32'h7fff_ffff, 32'h0);
    queue_request(REQ_CLEAR, 32'h0, 32'h0);

    // Wait until every response is in, then hold the sender back before the random part starts.
    hold_requests = 1'b0;
    wait_drained();
    hold_requests = 1'b1;
    repeat ($urandom_range(5, 20)) @(posedge clk);
    hold_requests = 1'b0;

    send_idle_pct = 34; take_idle_pct = 79;
    queue_random(550);
    wait_drained();
    send_idle_pct = 79; take_idle_pct = 34;
    queue_random(550);
    wait_drained();
    send_idle_pct = 0; take_idle_pct = 0;
    queue_random(550);
    wait_drained();
    repeat (20) @(posedge clk);

    if (!failed && expected_responses.size() == 0) begin
      $display("sorted_unique_pair_set_top_test: PASS");
    end else begin
      $display("sorted_unique_pair_set_top_test: FAIL");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #8_000_000;
    $display("sorted_unique_pair_set_top_test: FAIL");
    $finish;
  end
endmodule
`default_nettype wire

[filelist.f]
rtl/core/sups_pkg.sv
rtl/core/sups_if.sv
rtl/core/sups_ctrl.sv
rtl/core/sups_datapath.sv
rtl/core/sorted_unique_pair_set_top.sv
verif/sorted_unique_pair_set_top_test.sv
